@@ hw/rtl/whrt_pkg.sv @@
// shared types, codes and constants of the write region hazard tracker
package whrt_pkg;

   localparam int unsigned DEF_RANGE_SLOTS = 256;
   localparam int unsigned DEF_VOICE_COUNT = 8;

   localparam int unsigned OFFSET_W  = 24;
   localparam int unsigned VOICE_W   = 3;
   localparam int unsigned END_W     = 25;
   localparam int unsigned CLS_W     = 2;
   localparam int unsigned ACT_W     = 3;
   localparam int unsigned SLOT_W    = 12;
   localparam int unsigned SLOT_OUT_W  = 8;
   localparam int unsigned TOTAL_OUT_W = 9;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 25;
   localparam int unsigned REQ_DATA_W  = 32;
   localparam int unsigned RSP_DATA_W  = 72;

   // region classes
   localparam logic [CLS_W-1:0] CLS_MAIN   = 2'd0;
   localparam logic [CLS_W-1:0] CLS_AUX    = 2'd1;
   localparam logic [CLS_W-1:0] CLS_SHARED = 2'd2;
   localparam logic [CLS_W-1:0] CLS_HAZARD = 2'd3;

   // range table actions
   localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_INSIDE = 3'd1;
   localparam logic [ACT_W-1:0] ACT_END    = 3'd2;
   localparam logic [ACT_W-1:0] ACT_START  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_NEW    = 3'd4;
   localparam logic [ACT_W-1:0] ACT_DROP   = 3'd5;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_MAIN_BASE   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAIN_STRIDE = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_AUX_BASE    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_AUX_STRIDE  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SHARED_LOW  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_SHARED_HIGH = 3'd5;

   // register reset values
   localparam logic [23:0] RST_MAIN_BASE   = 24'd176;
   localparam logic [23:0] RST_MAIN_STRIDE = 24'd10512;
   localparam logic [23:0] RST_AUX_BASE    = 24'd101504;
   localparam logic [15:0] RST_AUX_STRIDE  = 16'd32;
   localparam logic [23:0] RST_SHARED_LOW  = 24'd84272;
   localparam logic [24:0] RST_SHARED_HIGH = 25'd84436;

   // one write travelling down the cell row
   typedef struct packed {
      logic                valid;
      logic [OFFSET_W-1:0] offset;
      logic [CLS_W-1:0]    cls;
      logic [ACT_W-1:0]    action;
      logic [SLOT_W-1:0]   slot;
      logic [OFFSET_W-1:0] range_start;
      logic [END_W-1:0]    range_end;
   } whrt_item_type;

endpackage

@@ hw/rtl/write_region_hazard_tracker_top.sv @@
// top level: classifier, row of range cells and result register
// each request passes classifier stages a and b, every range cell in order and the result register
// throughput: one request per cycle while the result is not stalled; each request walks the cell row one entry a cycle
// a stalled result freezes the whole row until it is taken
// reset: synchronous, clears region registers to defaults and empties the range table
// no clearing pass after reset; the block takes requests in the cycle after reset drops
module write_region_hazard_tracker_top #(
   parameter int unsigned RANGE_SLOTS = whrt_pkg::DEF_RANGE_SLOTS,
   parameter int unsigned VOICE_COUNT = whrt_pkg::DEF_VOICE_COUNT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [whrt_pkg::REQ_DATA_W-1:0]     req_tdata,  // offset, voice
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // region_class, range_action, range_slot, range_start, range_end, range_total
   output logic [whrt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [whrt_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [whrt_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import whrt_pkg::*;

   localparam int unsigned CNT_W = $clog2(RANGE_SLOTS + 1);

   logic          advance;
   whrt_item_type link [0:RANGE_SLOTS];
   whrt_item_type tail;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [ACT_W-1:0]          final_action;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   whrt_classify #(
      .VOICE_COUNT(VOICE_COUNT)
   ) u_classify (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .req_valid  (req_tvalid),
      .req_offset (req_tdata[OFFSET_W-1:0]),
      .req_voice  (req_tdata[OFFSET_W+VOICE_W-1:OFFSET_W]),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .item_out   (link[0])
   );

   for (genvar g = 0; g < RANGE_SLOTS; g++) begin : g_cell
      whrt_cell #(
         .CELL_IDX(g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .item_in_i (link[g]),
         .item_out  (link[g+1])
      );
   end

   assign tail = link[RANGE_SLOTS];

   always_comb begin
      final_action = tail.action;
      // a hazard that found neither a match nor a free entry is dropped
      if (tail.cls == CLS_HAZARD && tail.action == ACT_NONE) begin
         final_action = ACT_DROP;
      end
      count_in = count_ff;
      if (tail.valid && tail.action == ACT_NEW) begin
         count_in = count_ff + CNT_W'(1);
      end
      rsp_valid_in = tail.valid;
      rsp_data_in  = {1'b0,
                      TOTAL_OUT_W'(count_in),
                      tail.range_end,
                      tail.range_start,
                      tail.slot[SLOT_OUT_W-1:0],
                      final_action,
                      tail.cls};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hw/rtl/whrt_classify.sv @@
// region registers and two-stage region classification of each write
module whrt_classify #(
   parameter int unsigned VOICE_COUNT = whrt_pkg::DEF_VOICE_COUNT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                req_valid,
   input  logic [whrt_pkg::OFFSET_W-1:0]       req_offset,
   input  logic [whrt_pkg::VOICE_W-1:0]        req_voice,
   input  logic                                csr_wr_en,
   input  logic [whrt_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [whrt_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output whrt_pkg::whrt_item_type             item_out
);
   import whrt_pkg::*;

   logic [23:0] main_base_ff, main_stride_ff, aux_base_ff, shared_low_ff;
   logic [15:0] aux_stride_ff;
   logic [24:0] shared_high_ff;

   // stage a: block bases for the writing voice
   logic                valid_a_ff, valid_a_in;
   logic [OFFSET_W-1:0] offset_a_ff, offset_a_in;
   logic                voice_ok_a_ff, voice_ok_a_in;
   logic [26:0]         main_lo_a_ff, main_lo_a_in;
   logic [24:0]         aux_lo_a_ff, aux_lo_a_in;

   // stage b: class
   whrt_item_type item_ff, item_in;

   logic [27:0] main_hi;
   logic [25:0] aux_hi;
   logic        in_main, in_aux, in_shared;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_base_ff   <= RST_MAIN_BASE;
         main_stride_ff <= RST_MAIN_STRIDE;
         aux_base_ff    <= RST_AUX_BASE;
         aux_stride_ff  <= RST_AUX_STRIDE;
         shared_low_ff  <= RST_SHARED_LOW;
         shared_high_ff <= RST_SHARED_HIGH;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_MAIN_BASE:   main_base_ff   <= csr_wdata[23:0];
            CSR_MAIN_STRIDE: main_stride_ff <= csr_wdata[23:0];
            CSR_AUX_BASE:    aux_base_ff    <= csr_wdata[23:0];
            CSR_AUX_STRIDE:  aux_stride_ff  <= csr_wdata[15:0];
            CSR_SHARED_LOW:  shared_low_ff  <= csr_wdata[23:0];
            CSR_SHARED_HIGH: shared_high_ff <= csr_wdata[24:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      valid_a_in    = req_valid;
      offset_a_in   = req_offset;
      voice_ok_a_in = 32'(req_voice) < VOICE_COUNT;
      main_lo_a_in  = 27'(main_base_ff)
                    + 27'({3'b0, main_stride_ff} * {24'b0, req_voice});
      aux_lo_a_in   = 25'(aux_base_ff)
                    + 25'({3'b0, aux_stride_ff} * {16'b0, req_voice});
   end

   always_comb begin
      main_hi   = {1'b0, main_lo_a_ff} + 28'(main_stride_ff);
      aux_hi    = {1'b0, aux_lo_a_ff} + 26'(aux_stride_ff);
      in_main   = voice_ok_a_ff && (27'(offset_a_ff) >= main_lo_a_ff)
                  && (28'(offset_a_ff) < main_hi);
      in_aux    = voice_ok_a_ff && (25'(offset_a_ff) >= aux_lo_a_ff)
                  && (26'(offset_a_ff) < aux_hi);
      in_shared = (offset_a_ff >= shared_low_ff) && (25'(offset_a_ff) < shared_high_ff);

      item_in             = '0;
      item_in.valid       = valid_a_ff;
      item_in.offset      = offset_a_ff;
      item_in.action      = ACT_NONE;
      if (in_main)        item_in.cls = CLS_MAIN;
      else if (in_aux)    item_in.cls = CLS_AUX;
      else if (in_shared) item_in.cls = CLS_SHARED;
      else                item_in.cls = CLS_HAZARD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff    <= 1'b0;
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         valid_a_ff    <= valid_a_in;
         item_ff.valid <= item_in.valid;
      end
      if (advance) begin
         offset_a_ff         <= offset_a_in;
         voice_ok_a_ff       <= voice_ok_a_in;
         main_lo_a_ff        <= main_lo_a_in;
         aux_lo_a_ff         <= aux_lo_a_in;
         item_ff.offset      <= item_in.offset;
         item_ff.cls         <= item_in.cls;
         item_ff.action      <= item_in.action;
         item_ff.slot        <= item_in.slot;
         item_ff.range_start <= item_in.range_start;
         item_ff.range_end   <= item_in.range_end;
      end
   end

   assign item_out = item_ff;

endmodule

@@ hw/rtl/whrt_cell.sv @@
// one range table entry; tests and updates the request passing through it
module whrt_cell #(
   parameter int unsigned CELL_IDX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  whrt_pkg::whrt_item_type item_in_i,
   output whrt_pkg::whrt_item_type item_out
);
   import whrt_pkg::*;

   logic                used_ff, used_in;
   logic [OFFSET_W-1:0] start_ff, start_in;
   logic [END_W-1:0]    end_ff, end_in;
   whrt_item_type       item_ff, item_in;

   logic             pending;
   logic [END_W-1:0] off_ext, off_inc;

   always_comb begin
      pending  = item_in_i.valid && (item_in_i.cls == CLS_HAZARD)
                 && (item_in_i.action == ACT_NONE);
      off_ext  = {1'b0, item_in_i.offset};
      off_inc  = off_ext + 25'd1;
      used_in  = used_ff;
      start_in = start_ff;
      end_in   = end_ff;
      item_in  = item_in_i;

      if (pending) begin
         if (!used_ff) begin
            // first free entry takes the new range
            used_in        = 1'b1;
            start_in       = item_in_i.offset;
            end_in         = off_inc;
            item_in.action = ACT_NEW;
         end else if (off_ext >= {1'b0, start_ff} && off_ext < end_ff) begin
            item_in.action = ACT_INSIDE;
         end else if (off_ext == end_ff) begin
            end_in         = off_inc;
            item_in.action = ACT_END;
         end else if (off_inc == {1'b0, start_ff}) begin
            start_in       = item_in_i.offset;
            item_in.action = ACT_START;
         end
         if (item_in.action != ACT_NONE) begin
            item_in.slot        = SLOT_W'(CELL_IDX);
            item_in.range_start = start_in;
            item_in.range_end   = end_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= 1'b0;
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         used_ff       <= used_in;
         item_ff.valid <= item_in.valid;
      end
      if (advance) begin
         start_ff            <= start_in;
         end_ff              <= end_in;
         item_ff.offset      <= item_in.offset;
         item_ff.cls         <= item_in.cls;
         item_ff.action      <= item_in.action;
         item_ff.slot        <= item_in.slot;
         item_ff.range_start <= item_in.range_start;
         item_ff.range_end   <= item_in.range_end;
      end
   end

   assign item_out = item_ff;

endmodule

@@ dv/whrt_checker.sv @@
`timescale 1ns / 1ps
// checker for the hazard tracker: predicts each response from accepted requests and compares
module whrt_checker #(
   parameter int unsigned RANGE_SLOTS = whrt_pkg::DEF_RANGE_SLOTS,
   parameter int unsigned VOICE_COUNT = whrt_pkg::DEF_VOICE_COUNT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [whrt_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [whrt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [whrt_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [whrt_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                  fail_count,
   output int                                  open_count,
   output int                                  n_checked,
   output int                                  n_hazard,
   output int                                  n_grown,
   output int                                  n_dropped,
   output int                                  held_ranges
);
   import whrt_pkg::*;

   // lowest field last, so a cast of the response bits lines up
   typedef struct packed {
      logic [TOTAL_OUT_W-1:0] total;
      logic [END_W-1:0]       last_excl;
      logic [OFFSET_W-1:0]    first;
      logic [SLOT_OUT_W-1:0]  slot;
      logic [ACT_W-1:0]       act;
      logic [CLS_W-1:0]       cls;
   } verdict_type;

   verdict_type hazard_verdicts[$];

   logic [OFFSET_W-1:0] cfg_main_base, cfg_main_stride, cfg_aux_base, cfg_shared_low;
   logic [15:0]         cfg_aux_stride;
   logic [END_W-1:0]    cfg_shared_high;

   logic [OFFSET_W-1:0] hz_start [RANGE_SLOTS];
   logic [END_W-1:0]    hz_end   [RANGE_SLOTS];
   int unsigned         hz_used = 0;

   int mismatches = 0;
   int pending_depth = 0;
   int seen = 0, hazards = 0, grows = 0, drops = 0;

   assign fail_count  = mismatches;
   assign open_count  = pending_depth;
   assign n_checked   = seen;
   assign n_hazard    = hazards;
   assign n_grown     = grows;
   assign n_dropped   = drops;
   assign held_ranges = hz_used;

   task automatic classify_and_track(input logic [OFFSET_W-1:0] off,
                                     input logic [VOICE_W-1:0] v, output verdict_type res);
      logic [31:0]     o, lo;
      logic [END_W-1:0] o_next;
      bit              hit;
      res = '0;
      o = 32'(off);
      o_next = {1'b0, off} + 1'b1;
      hit = 0;
      res.cls = CLS_HAZARD;
      // bounds at 32 bits so a block past the top of the offset space never wraps
      if (32'(v) < VOICE_COUNT) begin
         lo = 32'(cfg_main_base) + 32'(v) * 32'(cfg_main_stride);
         if (o >= lo && o < lo + 32'(cfg_main_stride)) begin
            res.cls = CLS_MAIN;
         end else begin
            lo = 32'(cfg_aux_base) + 32'(v) * 32'(cfg_aux_stride);
            if (o >= lo && o < lo + 32'(cfg_aux_stride)) res.cls = CLS_AUX;
         end
      end
      if (res.cls == CLS_HAZARD && o >= 32'(cfg_shared_low) && o < 32'(cfg_shared_high))
         res.cls = CLS_SHARED;
      if (res.cls == CLS_HAZARD) begin
         // first matching entry wins, neighbors are never merged
         for (int i = 0; i < hz_used && !hit; i++) begin
            if (off >= hz_start[i] && {1'b0, off} < hz_end[i]) begin
               res.act = ACT_INSIDE;
               hit = 1;
            end else if ({1'b0, off} == hz_end[i]) begin
               hz_end[i] = o_next;
               res.act = ACT_END;
               hit = 1;
            end else if (o_next == {1'b0, hz_start[i]}) begin
               hz_start[i] = off;
               res.act = ACT_START;
               hit = 1;
            end
            if (hit) begin
               res.slot = SLOT_OUT_W'(i);
               res.first = hz_start[i];
               res.last_excl = hz_end[i];
            end
         end
         if (!hit) begin
            if (hz_used < RANGE_SLOTS) begin
               hz_start[hz_used] = off;
               hz_end[hz_used] = o_next;
               res.act = ACT_NEW;
               res.slot = SLOT_OUT_W'(hz_used);
               res.first = off;
               res.last_excl = o_next;
               hz_used++;
            end else begin
               res.act = ACT_DROP;
            end
         end
      end
      res.total = TOTAL_OUT_W'(hz_used);
   endtask

   task automatic check_field(input string name, input logic [31:0] want_v, got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      verdict_type want, got;
      if (reset) begin
         cfg_main_base   = RST_MAIN_BASE;
         cfg_main_stride = RST_MAIN_STRIDE;
         cfg_aux_base    = RST_AUX_BASE;
         cfg_aux_stride  = RST_AUX_STRIDE;
         cfg_shared_low  = RST_SHARED_LOW;
         cfg_shared_high = RST_SHARED_HIGH;
         hz_used = 0;
         hazard_verdicts.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_addr)
               CSR_MAIN_BASE:   cfg_main_base   = csr_wdata[OFFSET_W-1:0];
               CSR_MAIN_STRIDE: cfg_main_stride = csr_wdata[OFFSET_W-1:0];
               CSR_AUX_BASE:    cfg_aux_base    = csr_wdata[OFFSET_W-1:0];
               CSR_AUX_STRIDE:  cfg_aux_stride  = csr_wdata[15:0];
               CSR_SHARED_LOW:  cfg_shared_low  = csr_wdata[OFFSET_W-1:0];
               CSR_SHARED_HIGH: cfg_shared_high = csr_wdata[END_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            classify_and_track(req_tdata[OFFSET_W-1:0],
                               req_tdata[OFFSET_W+VOICE_W-1:OFFSET_W], want);
            hazard_verdicts.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = verdict_type'(rsp_tdata[$bits(verdict_type)-1:0]);
            if (hazard_verdicts.size() == 0) begin
               $error("response with no request waiting");
               mismatches++;
            end else begin
               want = hazard_verdicts.pop_front();
               check_field("region_class", want.cls, got.cls);
               check_field("range_action", want.act, got.act);
               check_field("range_slot", want.slot, got.slot);
               check_field("range_start", want.first, got.first);
               check_field("range_end", want.last_excl, got.last_excl);
               check_field("range_total", want.total, got.total);
               seen++;
               if (want.cls == CLS_HAZARD) hazards++;
               if (want.act == ACT_END || want.act == ACT_START) grows++;
               if (want.act == ACT_DROP) drops++;
            end
         end
      end
      pending_depth <= hazard_verdicts.size();
   end

endmodule

@@ dv/write_region_hazard_tracker_top_tb.sv @@
`timescale 1ns / 1ps
// testbench top: drives writes and register settings into the hazard tracker and gives the verdict
module write_region_hazard_tracker_top_tb;
   import whrt_pkg::*;

   localparam int unsigned LATENCY    = DEF_RANGE_SLOTS + 3;
   localparam int unsigned IDLE_LIMIT = 4000;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_7 = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // offset, voice
   logic                  rsp_tready = 1'b0;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   wire                   req_tready;
   wire                   rsp_tvalid;
   // region_class, range_action, range_slot, range_start, range_end, range_total
   wire [RSP_DATA_W-1:0]  rsp_tdata;

   int fail_count, open_count, n_checked, n_hazard, n_grown, n_dropped, held_ranges;
   int idle_cycles = 0;
   int burst_left = 0;
   int rsp_mode = 0;
   int rsp_cyc = 0;

   // stimulus-side copy of the settings, used only to aim offsets at regions
   logic [OFFSET_W-1:0] cfg_main_base = RST_MAIN_BASE;
   logic [OFFSET_W-1:0] cfg_main_stride = RST_MAIN_STRIDE;
   logic [OFFSET_W-1:0] cfg_aux_base = RST_AUX_BASE;
   logic [15:0]         cfg_aux_stride = RST_AUX_STRIDE;
   logic [OFFSET_W-1:0] cfg_shared_low = RST_SHARED_LOW;
   logic [END_W-1:0]    cfg_shared_high = RST_SHARED_HIGH;
   logic [31:0]         hot_spot [8];

   always #1 clock = ~clock;

   write_region_hazard_tracker_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   whrt_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .open_count  (open_count),
      .n_checked   (n_checked),
      .n_hazard    (n_hazard),
      .n_grown     (n_grown),
      .n_dropped   (n_dropped),
      .held_ranges (held_ranges)
   );

   // response side switches among four stall patterns, picked at random
   always @(negedge clock) begin
      if (rsp_cyc % 48 == 0) rsp_mode = $urandom_range(0, 3);
      rsp_cyc++;
      case (rsp_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ((rsp_cyc % 7) < 4);
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic push_write(input logic [OFFSET_W-1:0] off, input logic [VOICE_W-1:0] v);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tdata <= {{(REQ_DATA_W-OFFSET_W-VOICE_W){1'b0}}, v, off};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_MAIN_BASE:   cfg_main_base = val[OFFSET_W-1:0];
         CSR_MAIN_STRIDE: cfg_main_stride = val[OFFSET_W-1:0];
         CSR_AUX_BASE:    cfg_aux_base = val[OFFSET_W-1:0];
         CSR_AUX_STRIDE:  cfg_aux_stride = val[15:0];
         CSR_SHARED_LOW:  cfg_shared_low = val[OFFSET_W-1:0];
         CSR_SHARED_HIGH: cfg_shared_high = val[END_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // drain the pipeline before touching registers
   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic reseed_hot_spots();
      for (int i = 0; i < 8; i++)
         hot_spot[i] = (i < 3) ? $urandom_range(8, 168) : $urandom_range(0, 24'hFFFFFF);
   endtask

   // scatter out of ten goes to uniform offsets, the rest aims at regions and clusters
   task automatic random_writes(input int count, input int scatter);
      logic [31:0]        pick, main_lo, aux_lo;
      logic [VOICE_W-1:0] v;
      for (int n = 0; n < count; n++) begin
         v = VOICE_W'($urandom_range(0, 7));
         main_lo = 32'(cfg_main_base) + 32'(v) * 32'(cfg_main_stride);
         aux_lo = 32'(cfg_aux_base) + 32'(v) * 32'(cfg_aux_stride);
         pick = $urandom;
         if ($urandom_range(0, 9) >= scatter) begin
            case ($urandom_range(0, 9))
               0, 1: if (cfg_main_stride != 0) pick = main_lo + $urandom % cfg_main_stride;
               2: if (cfg_aux_stride != 0) pick = aux_lo + $urandom % cfg_aux_stride;
               3: if (cfg_shared_high > cfg_shared_low)
                     pick = cfg_shared_low + $urandom % (cfg_shared_high - cfg_shared_low);
               4: begin
                  case ($urandom_range(0, 5))
                     0: pick = main_lo - 1;
                     1: pick = main_lo + cfg_main_stride;
                     2: pick = aux_lo - 1;
                     3: pick = aux_lo + cfg_aux_stride;
                     4: pick = 32'(cfg_shared_high);
                     default: pick = cfg_shared_low - 1;
                  endcase
               end
               default: pick = hot_spot[$urandom_range(0, 7)] + $urandom_range(0, 16) - 8;
            endcase
         end
         push_write(pick[OFFSET_W-1:0], v);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: each class, then grow and hit ranges at both ends of the space
      push_write(RST_MAIN_BASE, 3'd0);
      push_write(OFFSET_W'(RST_MAIN_BASE + RST_MAIN_STRIDE - 1), 3'd0);
      push_write(OFFSET_W'(RST_MAIN_BASE + 7 * RST_MAIN_STRIDE), 3'd7);
      push_write(RST_MAIN_BASE, 3'd1);          // someone else's main block
      push_write(OFFSET_W'(RST_MAIN_BASE + 1), 3'd1);
      push_write(OFFSET_W'(RST_MAIN_BASE - 1), 3'd2);
      push_write(RST_MAIN_BASE, 3'd3);
      push_write(RST_AUX_BASE, 3'd0);
      push_write(OFFSET_W'(RST_AUX_BASE + 8 * RST_AUX_STRIDE - 1), 3'd7);
      push_write(RST_SHARED_LOW, 3'd5);
      push_write(OFFSET_W'(RST_SHARED_HIGH - 1), 3'd5);
      push_write(RST_SHARED_HIGH[OFFSET_W-1:0], 3'd5);
      push_write(24'd0, 3'd0);
      push_write(24'hFFFFFF, 3'd7);
      push_write(24'hFFFFFE, 3'd7);
      push_write(24'hFFFFFF, 3'd6);
      push_write(24'd1, 3'd0);
      push_write(RST_SHARED_HIGH[OFFSET_W-1:0], 3'd4);
      push_write(OFFSET_W'(RST_SHARED_HIGH + 1), 3'd5);

      reseed_hot_spots();
      random_writes(150, 1);

      // widest blocks, shared window over the whole space
      settle();
      write_reg(CSR_MAIN_BASE, 25'hFFFFFF);
      write_reg(CSR_MAIN_STRIDE, 25'hFFFFFF);
      write_reg(CSR_AUX_BASE, 25'd0);
      write_reg(CSR_AUX_STRIDE, 25'hFFFF);
      write_reg(CSR_SHARED_LOW, 25'd0);
      write_reg(CSR_SHARED_HIGH, 25'h1000000);
      csr_wr_en <= 1'b0;
      push_write(24'hFFFFFF, 3'd0);
      push_write(24'hFFFFFF, 3'd1);
      push_write(24'd0, 3'd0);
      random_writes(50, 2);

      // empty blocks and inverted window: every write is a hazard, table fills and drops
      settle();
      write_reg(CSR_MAIN_STRIDE, 25'd0);
      write_reg(CSR_AUX_STRIDE, 25'd0);
      write_reg(CSR_SHARED_LOW, 25'h800000);
      write_reg(CSR_SHARED_HIGH, 25'h100);
      write_reg(CSR_SPARE_6, 25'h1FFFFFF);
      write_reg(CSR_SPARE_7, 25'h0AAAAA);
      csr_wr_en <= 1'b0;
      reseed_hot_spots();
      random_writes(300, 8);

      // unit strides and an empty window with a full table
      settle();
      write_reg(CSR_MAIN_BASE, 25'd0);
      write_reg(CSR_MAIN_STRIDE, 25'd1);
      write_reg(CSR_AUX_BASE, 25'd0);
      write_reg(CSR_AUX_STRIDE, 25'd1);
      write_reg(CSR_SHARED_LOW, 25'h1234);
      write_reg(CSR_SHARED_HIGH, 25'h1234);
      write_reg(CSR_SPARE_6, 25'h155555);
      csr_wr_en <= 1'b0;
      random_writes(100, 1);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);

      $display("checked %0d responses under four register settings:", n_checked);
      $display("%0d hazards, %0d grows, %0d drops, range table ended with %0d of %0d in use",
               n_hazard, n_grown, n_dropped, held_ranges, DEF_RANGE_SLOTS);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
